### src/assert_macros.svh
// Assertion helpers. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PPT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PPT_ASSERT(lbl, prop, msg)
`define PPT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### src/ppt_pkg.sv
package ppt_pkg;

	localparam int PAGE_BYTES_DEF    = 4096;
	localparam int PROCESS_SLOTS_DEF = 16;
	localparam int QUEUE_DEPTH       = 2;

	// fixed field widths
	localparam int PID_W   = 4;
	localparam int REGION_W = 31;
	localparam int LADDR_W = 32;
	localparam int PADDR_W = 31;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		OP_CREATE    = 2'd0,
		OP_REMOVE    = 2'd1,
		OP_TRANSLATE = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_REPLACED   = 3'd1,
		ST_NO_TABLE   = 3'd2,
		ST_NEGATIVE   = 3'd3,
		ST_PAGE_FAULT = 3'd4
	} status_t;

	// classification made at the front, carried through the queue
	typedef struct packed {
		op_t  op;
		logic slot_ok;
		logic negative;
	} cls_t;

endpackage

### src/per_process_page_translator_top.sv
// Per-process page translator.
// Request channel (req_valid / req_stall): opcode, process_id, region_start,
// region_size, logical_address. Create maps a region onto consecutive frames,
// remove drops a table, translate turns a logical address into a physical one.
// Response channel (rsp_valid / rsp_stall): physical_address and status, one
// transaction per create, remove or translate; opcode 3 is taken and dropped.
// A transaction is taken when valid is high and stall is low at a clock edge.
// Front end classifies the request and computes page counts, a two-entry
// queue decouples it from the back end, which owns the tables.
// The back end pops a queued request while idle and offers its response from
// S_OUT, after S_LOOK for a translate that reaches the table lookup (registered
// read of the frame/page-count RAM). The sequencer finishes one transaction
// before popping the next; the queue takes requests while a response waits.
// Reset (arst_n low) drops all tables and empties the queue; frame RAM needs
// no clearing as entries are only read behind their valid bit.
// A stalled response holds its fields; the back end waits and the request
// side stalls once the queue is full.
module per_process_page_translator_top #(
	parameter int PAGE_BYTES    = ppt_pkg::PAGE_BYTES_DEF,
	parameter int PROCESS_SLOTS = ppt_pkg::PROCESS_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         opcode,
	input  logic [ppt_pkg::PID_W-1:0]          process_id,
	input  logic [ppt_pkg::REGION_W-1:0]       region_start,
	input  logic [ppt_pkg::REGION_W-1:0]       region_size,
	input  logic signed [ppt_pkg::LADDR_W-1:0] logical_address,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ppt_pkg::PADDR_W-1:0]        physical_address,
	output logic [ppt_pkg::STATUS_W-1:0]       status
);

	localparam int PAGE_BITS = $clog2(PAGE_BYTES);
	localparam int SLOT_W    = $clog2(PROCESS_SLOTS);
	localparam int FRAME_W   = ppt_pkg::PADDR_W - PAGE_BITS;
	localparam int PAGES_W   = ppt_pkg::PADDR_W + 1 - PAGE_BITS;
	localparam int CLS_W     = $bits(ppt_pkg::cls_t);
	// queue word: class, slot, frame, page count, page, offset
	localparam int Q_W = CLS_W + SLOT_W + FRAME_W + PAGES_W + FRAME_W + PAGE_BITS;

	// front end outputs
	logic                 push;
	ppt_pkg::cls_t        push_cls;
	logic [SLOT_W-1:0]    push_slot;
	logic [FRAME_W-1:0]   push_frame;
	logic [PAGES_W-1:0]   push_pages;
	logic [FRAME_W-1:0]   push_page;
	logic [PAGE_BITS-1:0] push_offset;

	// queue head as seen by the back end
	logic                 q_full;
	logic                 q_not_empty;
	logic                 pop;
	logic [Q_W-1:0]       head_data;
	ppt_pkg::cls_t        head_cls;
	logic [SLOT_W-1:0]    head_slot;
	logic [FRAME_W-1:0]   head_frame;
	logic [PAGES_W-1:0]   head_pages;
	logic [FRAME_W-1:0]   head_page;
	logic [PAGE_BITS-1:0] head_offset;

	ppt_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.PROCESS_SLOTS(PROCESS_SLOTS)
	) u_front (
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.process_id     (process_id),
		.region_start   (region_start),
		.region_size    (region_size),
		.logical_address(logical_address),
		.q_full         (q_full),
		.push           (push),
		.cls            (push_cls),
		.slot           (push_slot),
		.frame          (push_frame),
		.pages          (push_pages),
		.page           (push_page),
		.offset         (push_offset)
	);

	ppt_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_cls, push_slot, push_frame, push_pages, push_page, push_offset}),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head_data(head_data)
	);

	assign {head_cls, head_slot, head_frame, head_pages, head_page, head_offset} = head_data;

	ppt_back #(
		.PAGE_BYTES   (PAGE_BYTES),
		.PROCESS_SLOTS(PROCESS_SLOTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (q_not_empty),
		.pop             (pop),
		.head_cls        (head_cls),
		.head_slot       (head_slot),
		.head_frame      (head_frame),
		.head_pages      (head_pages),
		.head_page       (head_page),
		.head_offset     (head_offset),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.physical_address(physical_address),
		.status          (status)
	);

endmodule

### src/ppt_ram.sv
module ppt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/ppt_queue.sv
module ppt_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head_data
);

	localparam int DEPTH = ppt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/ppt_front.sv
module ppt_front #(
	parameter int PAGE_BYTES    = ppt_pkg::PAGE_BYTES_DEF,
	parameter int PROCESS_SLOTS = ppt_pkg::PROCESS_SLOTS_DEF,
	localparam int PAGE_BITS = $clog2(PAGE_BYTES),
	localparam int SLOT_W    = $clog2(PROCESS_SLOTS),
	localparam int FRAME_W   = ppt_pkg::PADDR_W - PAGE_BITS,
	localparam int PAGES_W   = ppt_pkg::PADDR_W + 1 - PAGE_BITS
) (
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [1:0]                      opcode,
	input  logic [ppt_pkg::PID_W-1:0]       process_id,
	input  logic [ppt_pkg::REGION_W-1:0]    region_start,
	input  logic [ppt_pkg::REGION_W-1:0]    region_size,
	input  logic signed [ppt_pkg::LADDR_W-1:0] logical_address,
	input  logic                            q_full,
	output logic                            push,
	output ppt_pkg::cls_t                   cls,
	output logic [SLOT_W-1:0]               slot,
	output logic [FRAME_W-1:0]              frame,
	output logic [PAGES_W-1:0]              pages,
	output logic [FRAME_W-1:0]              page,
	output logic [PAGE_BITS-1:0]            offset
);

	logic [31:0] size_round;

	assign req_stall = q_full;
	// unused opcode is taken and dropped
	assign push = req_valid && !q_full && (ppt_pkg::op_t'(opcode) != ppt_pkg::OP_NONE);

	assign cls.op       = ppt_pkg::op_t'(opcode);
	assign cls.slot_ok  = (32'(process_id) < 32'(PROCESS_SLOTS));
	assign cls.negative = logical_address[ppt_pkg::LADDR_W-1];

	assign slot = SLOT_W'(process_id);

	// ceil(size / page) without overflow
	assign size_round = 32'(region_size) + 32'(PAGE_BYTES - 1);
	assign pages      = size_round[31:PAGE_BITS];
	assign frame      = region_start[ppt_pkg::REGION_W-1:PAGE_BITS];

	assign page   = logical_address[ppt_pkg::PADDR_W-1:PAGE_BITS];
	assign offset = logical_address[PAGE_BITS-1:0];

endmodule

### src/ppt_back.sv
`include "assert_macros.svh"

module ppt_back #(
	parameter int PAGE_BYTES    = ppt_pkg::PAGE_BYTES_DEF,
	parameter int PROCESS_SLOTS = ppt_pkg::PROCESS_SLOTS_DEF,
	localparam int PAGE_BITS = $clog2(PAGE_BYTES),
	localparam int SLOT_W    = $clog2(PROCESS_SLOTS),
	localparam int FRAME_W   = ppt_pkg::PADDR_W - PAGE_BITS,
	localparam int PAGES_W   = ppt_pkg::PADDR_W + 1 - PAGE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	output logic                          pop,
	input  ppt_pkg::cls_t                 head_cls,
	input  logic [SLOT_W-1:0]             head_slot,
	input  logic [FRAME_W-1:0]            head_frame,
	input  logic [PAGES_W-1:0]            head_pages,
	input  logic [FRAME_W-1:0]            head_page,
	input  logic [PAGE_BITS-1:0]          head_offset,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [ppt_pkg::PADDR_W-1:0]   physical_address,
	output logic [ppt_pkg::STATUS_W-1:0]  status
);

	localparam int ENTRY_W = FRAME_W + PAGES_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_OUT
	} state_t;

	state_t                      state_q;
	logic [PROCESS_SLOTS-1:0]    valid_q;
	logic [FRAME_W-1:0]          page_q;
	logic [PAGE_BITS-1:0]        offset_q;
	logic [ppt_pkg::PADDR_W-1:0] phys_q;
	ppt_pkg::status_t            status_q;

	logic                        ram_we;
	logic [ENTRY_W-1:0]          ram_rdata;
	logic [FRAME_W-1:0]          rd_frame;
	logic [PAGES_W-1:0]          rd_pages;
	logic                        slot_live;
	logic [FRAME_W:0]            frame_sum;
	logic [ppt_pkg::PADDR_W:0]   phys_full;

	assign pop       = (state_q == S_IDLE) && head_valid;
	assign ram_we    = pop && (head_cls.op == ppt_pkg::OP_CREATE) && head_cls.slot_ok;
	assign slot_live = head_cls.slot_ok && valid_q[head_slot];

	// frame and page count live in one word per slot
	ppt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PROCESS_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_slot),
		.wdata({head_frame, head_pages}),
		.raddr(head_slot),
		.rdata(ram_rdata)
	);

	assign {rd_frame, rd_pages} = ram_rdata;
	assign frame_sum = (FRAME_W + 1)'(rd_frame) + (FRAME_W + 1)'(page_q);
	assign phys_full = {frame_sum, offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						page_q   <= head_page;
						offset_q <= head_offset;
						phys_q   <= '0;
						unique case (head_cls.op)
							ppt_pkg::OP_CREATE: begin
								state_q <= S_OUT;
								if (head_cls.slot_ok) begin
									status_q <= valid_q[head_slot] ? ppt_pkg::ST_REPLACED
										: ppt_pkg::ST_OK;
									valid_q[head_slot] <= 1'b1;
								end else begin
									status_q <= ppt_pkg::ST_NO_TABLE;
								end
							end
							ppt_pkg::OP_REMOVE: begin
								state_q <= S_OUT;
								if (slot_live) begin
									status_q <= ppt_pkg::ST_OK;
									valid_q[head_slot] <= 1'b0;
								end else begin
									status_q <= ppt_pkg::ST_NO_TABLE;
								end
							end
							ppt_pkg::OP_TRANSLATE: begin
								if (head_cls.negative) begin
									status_q <= ppt_pkg::ST_NEGATIVE;
									state_q  <= S_OUT;
								end else if (!slot_live) begin
									status_q <= ppt_pkg::ST_NO_TABLE;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_LOOK;
								end
							end
							ppt_pkg::OP_NONE: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LOOK: begin
					state_q <= S_OUT;
					if (PAGES_W'(page_q) < rd_pages) begin
						status_q <= ppt_pkg::ST_OK;
						phys_q   <= phys_full[ppt_pkg::PADDR_W-1:0];
					end else begin
						status_q <= ppt_pkg::ST_PAGE_FAULT;
					end
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid        = (state_q == S_OUT);
	assign physical_address = phys_q;
	assign status           = status_q;

	`PPT_ASSERT(a_look_from_idle, (state_q == S_LOOK) |-> ($past(state_q) == S_IDLE), "lookup without a popped transaction")
	`PPT_ASSERT(a_fault_zero_addr, (rsp_valid && status_q != ppt_pkg::ST_OK) |-> (phys_q == '0), "non-zero address on a fault")
	`PPT_ASSERT(a_create_sets_valid, ram_we |=> valid_q[$past(head_slot)], "create left its slot invalid")

endmodule
